### hw/rtl/sfa_pkg.sv
// shared types, constants and helpers of the sprite frame animator
package sfa_pkg;

  // slot table size and derived widths
  localparam int SPRITE_SLOTS = 64;
  localparam int SLOT_AW      = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;
  localparam int SLOT_W       = 6;
  localparam int WALK_W       = SLOT_W + 1;
  localparam int VADDR_W      = 17;
  localparam int ATTR_W       = 18;
  localparam int STEP_W       = 16;
  localparam int PROD_W       = 24;
  localparam int FADDR_W      = 25;
  localparam int ATTR_SHIFT   = 3;
  localparam int CFG_W        = 17;
  localparam logic [7:0]         HIGH_MARK      = 8'h80;
  localparam logic [VADDR_W-1:0] ATTR_BASE_RST  = 17'd130048;

  // flag bit positions
  localparam int FLAG_ACTIVE   = 0;
  localparam int FLAG_REPEAT   = 1;
  localparam int FLAG_FINISHED = 2;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_FIRST_SLOT = 2'd0,
    CFG_LAST_SLOT  = 2'd1,
    CFG_ATTR_BASE  = 2'd2
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EVAL,
    ST_EMIT,
    ST_FLUSH
  } state_e;

  // input word
  typedef struct packed {
    logic               kind;
    logic [SLOT_W-1:0]  slot;
    logic [VADDR_W-1:0] frame0_address;
    logic [7:0]         frame_width;
    logic [7:0]         frame_height;
    logic [7:0]         frame_count;
    logic [7:0]         frame_wait;
    logic [7:0]         meta_flags;
    logic [7:0]         extra_flags;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [SLOT_W-1:0] out_slot;
    logic [ATTR_W-1:0] attr_address;
    logic [7:0]        addr_low_byte;
    logic [7:0]        addr_high_byte;
    logic              finished;
    logic              last;
  } out_word_t;

  // one slot table entry
  typedef struct packed {
    logic               act;
    logic               rpt;
    logic               fin;
    logic [7:0]         tick_cnt;
    logic [7:0]         frame_idx;
    logic [7:0]         wait_lim;
    logic [7:0]         frames_tot;
    logic [STEP_W-1:0]  frame_step;
    logic [VADDR_W-1:0] base_addr;
  } slot_entry_t;

  // build an attribute write word from slot, attribute base and frame address
  function automatic out_word_t make_word(input logic [SLOT_W-1:0]  slot,
                                          input logic [VADDR_W-1:0] attr_base,
                                          input logic [FADDR_W-1:0] faddr,
                                          input logic               fin);
    out_word_t w;
    w.out_slot       = slot;
    w.attr_address   = ATTR_W'(attr_base) + (ATTR_W'(slot) << ATTR_SHIFT);
    w.addr_low_byte  = faddr[12:5];
    w.addr_high_byte = HIGH_MARK | faddr[20:13];
    w.finished       = fin;
    w.last           = 1'b0;
    return w;
  endfunction

endpackage

### hw/rtl/sprite_frame_animator_top.sv
// sprite frame animator: slot table memory, tick walker and attribute word output
//
// Each slot lives in one word of a single-port synchronous table (one read or one write
// per cycle, read data registered). A prepare word writes its slot and yields one output
// word, which is released through the flush state. A tick walks the slots from first_slot
// to last_slot and stops early at the first inactive slot: a table read and an evaluate
// step per visited slot, with write back for slots of more than one frame, an emit step
// for each slot whose frame advances (frame address add), and a range check and a flush
// of the held word at the end. Every output word of a tick is held back one word so that
// the final one can carry last. The table needs no clearing after reset: a valid bit
// per slot marks slots written by prepare, and other slots read as inactive.
module sprite_frame_animator_top import sfa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_word_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // state and configuration
  state_e               state_q, state_d;
  logic [WALK_W-1:0]    cur_q, cur_d;
  logic [SLOT_W-1:0]    first_slot_q, last_slot_q;
  logic [VADDR_W-1:0]   attr_base_q;

  // slot table
  slot_entry_t          tbl_mem [SPRITE_SLOTS];
  logic [SPRITE_SLOTS-1:0] valid_q;
  logic                 mem_we;
  logic [SLOT_AW-1:0]   mem_waddr;
  slot_entry_t          mem_wdata;
  logic                 rd_en;
  logic [SLOT_AW-1:0]   rd_addr;
  slot_entry_t          rd_data_q;
  logic                 rd_valid_q;

  // emit stage
  logic [SLOT_W-1:0]    em_slot_q;
  logic [VADDR_W-1:0]   em_base_q;
  logic [PROD_W-1:0]    em_prod_q;
  logic                 em_fin_q;
  logic [FADDR_W-1:0]   em_faddr;
  out_word_t            em_word;

  // pending and output words
  out_word_t            pend_q, pend_d;
  logic                 pend_valid_q, pend_valid_d;
  out_word_t            out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;
  logic                 push;

  // handshake helpers
  logic                 in_acc;
  logic                 prep_ok;
  logic                 walk_in_range;
  slot_entry_t          prep_entry;
  logic [7:0]           prep_flags;
  out_word_t            prep_word;

  // tick evaluation
  slot_entry_t          cur_e, new_e;
  logic                 active, multi, expire, wrap, advance;
  logic [7:0]           tick_n, frame_inc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign prep_ok     = in_acc && in_word_i.kind &&
                       ({1'b0, in_word_i.slot} < WALK_W'(SPRITE_SLOTS));
  assign walk_in_range = (cur_q <= {1'b0, last_slot_q}) &&
                         (cur_q < WALK_W'(SPRITE_SLOTS));
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // prepare entry and its word
  always_comb begin
    prep_flags            = in_word_i.meta_flags | in_word_i.extra_flags;
    prep_entry.act        = prep_flags[FLAG_ACTIVE];
    prep_entry.rpt        = prep_flags[FLAG_REPEAT];
    prep_entry.fin        = prep_flags[FLAG_FINISHED];
    prep_entry.tick_cnt   = 8'd0;
    prep_entry.frame_idx  = 8'd0;
    prep_entry.wait_lim   = in_word_i.frame_wait;
    prep_entry.frames_tot = in_word_i.frame_count;
    prep_entry.frame_step = {8'd0, in_word_i.frame_width} * {8'd0, in_word_i.frame_height};
    prep_entry.base_addr  = in_word_i.frame0_address;
    prep_word = make_word(in_word_i.slot, attr_base_q,
                          FADDR_W'(in_word_i.frame0_address), prep_flags[FLAG_FINISHED]);
  end

  // timer and frame update of the slot just read
  always_comb begin
    cur_e     = rd_data_q;
    active    = rd_valid_q && cur_e.act;
    tick_n    = cur_e.tick_cnt + 8'd1;
    frame_inc = cur_e.frame_idx + 8'd1;
    multi     = cur_e.frames_tot > 8'd1;
    expire    = tick_n > cur_e.wait_lim;
    wrap      = frame_inc >= cur_e.frames_tot;
    advance   = active && multi && expire;
    new_e     = cur_e;
    if (multi) begin
      new_e.tick_cnt = expire ? 8'd0 : tick_n;
      if (expire) begin
        if (!wrap) begin
          new_e.frame_idx = frame_inc;
        end else if (cur_e.rpt) begin
          new_e.frame_idx = 8'd0;
        end else begin
          new_e.frame_idx = cur_e.frames_tot - 8'd1;
          new_e.fin       = 1'b1;
        end
      end
    end
  end

  // frame address of the advanced slot
  assign em_faddr = FADDR_W'(em_base_q) + FADDR_W'(em_prod_q);
  assign em_word  = make_word(em_slot_q, attr_base_q, em_faddr, em_fin_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_word_i.kind) state_d = ST_RD;
          else if (prep_ok)    state_d = ST_FLUSH;
        end
      end
      ST_RD: begin
        if (walk_in_range)     state_d = ST_EVAL;
        else if (pend_valid_q) state_d = ST_FLUSH;
        else                   state_d = ST_IDLE;
      end
      ST_EVAL: begin
        if (!active)           state_d = pend_valid_q ? ST_FLUSH : ST_IDLE;
        else if (advance)      state_d = ST_EMIT;
        else                   state_d = ST_RD;
      end
      ST_EMIT: begin
        if (!pend_valid_q || out_free) state_d = ST_RD;
      end
      ST_FLUSH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // table access, walk pointer and word movement
  always_comb begin
    rd_en        = (state_q == ST_RD) && walk_in_range;
    rd_addr      = cur_q[SLOT_AW-1:0];
    mem_we       = 1'b0;
    mem_waddr    = in_word_i.slot[SLOT_AW-1:0];
    mem_wdata    = prep_entry;
    cur_d        = cur_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    push         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (prep_ok) begin
          mem_we       = 1'b1;
          pend_d       = prep_word;
          pend_valid_d = 1'b1;
        end
        if (in_acc && !in_word_i.kind) cur_d = {1'b0, first_slot_q};
      end
      ST_EVAL: begin
        if (active) begin
          cur_d = cur_q + WALK_W'(1);
          if (multi) begin
            mem_we    = 1'b1;
            mem_waddr = cur_q[SLOT_AW-1:0];
            mem_wdata = new_e;
          end
        end
      end
      ST_EMIT: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            push  = 1'b1;
            out_d = pend_q;
          end
          pend_d       = em_word;
          pend_valid_d = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          push         = 1'b1;
          out_d        = pend_q;
          out_d.last   = 1'b1;
          pend_valid_d = 1'b0;
        end
      end
      default: begin
        cur_d = cur_q;
      end
    endcase
    out_valid_d = push ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cur_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      valid_q      <= '0;
      rd_valid_q   <= 1'b0;
      first_slot_q <= '0;
      last_slot_q  <= '0;
      attr_base_q  <= ATTR_BASE_RST;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (mem_we) valid_q[mem_waddr] <= 1'b1;
      if (rd_en)  rd_valid_q <= valid_q[rd_addr];
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FIRST_SLOT: first_slot_q <= cfg_data_i[SLOT_W-1:0];
          CFG_LAST_SLOT:  last_slot_q  <= cfg_data_i[SLOT_W-1:0];
          CFG_ATTR_BASE:  attr_base_q  <= cfg_data_i[VADDR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // slot table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) tbl_mem[mem_waddr] <= mem_wdata;
    if (rd_en)  rd_data_q <= tbl_mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    if (state_q == ST_EVAL) begin
      em_slot_q <= cur_q[SLOT_W-1:0];
      em_base_q <= cur_e.base_addr;
      em_prod_q <= {16'd0, new_e.frame_idx} * {8'd0, cur_e.frame_step};
      em_fin_q  <= new_e.fin;
    end
  end

  // no word is held back while a new input word can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_valid_q)
    else $error("pending word left over in idle");

  // the flush state always has a word to release
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> pend_valid_q)
    else $error("flush without pending word");

  // table data is only evaluated right after a read was issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> $past(rd_en))
    else $error("evaluation without table read");

  // table writes only come from prepare or write back of an evaluated slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_EVAL) || prep_ok)
    else $error("unexpected table write");

  // an emitted walk word never leaves with last set outside flush
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && (state_q == ST_EMIT)) |=> !out_word_o.last)
    else $error("last set on a middle word");

endmodule
